// ----- rtl/esd_pkg.sv -----
// Shared types, character codes and helper functions of the escape sequence decoder.
package esd_pkg;

	// Parse modes of the decoder.
	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_BACKSLASH = 2'd1,
		MODE_HEX       = 2'd2
	} mode_t;

	// Kinds of numeric escape.
	typedef enum logic [1:0] {
		KIND_X  = 2'd0,
		KIND_U4 = 2'd1,
		KIND_U8 = 2'd2
	} kind_t;

	// Sequencer states.
	typedef enum logic {
		SQ_IDLE = 1'b0,
		SQ_EMIT = 1'b1
	} seq_state_t;

	localparam logic [15:0] CH_BSLASH   = 16'h005C;
	localparam logic [15:0] CH_ESC      = 16'h001B;
	localparam logic [15:0] SURR_HI_OFS = 16'hD7C0;
	localparam logic [15:0] SURR_LO_OFS = 16'hDC00;
	localparam int unsigned DIGIT_W     = 7;
	localparam int unsigned STORE_DEPTH = 8;

	// Everything the sequencer needs to play out the results of one item.
	typedef struct packed {
		logic [3:0]         rep_len;   // backslash, letter and digits replayed first
		logic [DIGIT_W-1:0] letter;    // escape letter used in the replay
		logic [1:0]         main_cnt;  // results following the replay
		logic [15:0]        base0;
		logic [15:0]        add0;
		logic [15:0]        base1;
		logic [15:0]        add1;
		logic               text_end;  // the item closes the text
	} plan_t;

	function automatic logic [DIGIT_W-1:0] kind_letter(input kind_t k);
		logic [DIGIT_W-1:0] r;
		case (k)
			KIND_X:  r = 7'h78;
			KIND_U4: r = 7'h75;
			default: r = 7'h55;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] kind_need(input kind_t k);
		logic [3:0] r;
		case (k)
			KIND_X:  r = 4'd2;
			KIND_U4: r = 4'd4;
			default: r = 4'd8;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/esd_parser.sv -----
// Parse state of the escape decoder and the per-item result plan.
module esd_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [15:0]                   code_unit,
	input  logic                          stream_end,
	input  logic [2:0]                    rd_idx,
	output logic [esd_pkg::DIGIT_W-1:0]   rd_digit,
	output esd_pkg::plan_t                plan
);

	esd_pkg::mode_t mode_q, mode_n;
	esd_pkg::kind_t kind_q, kind_n;
	logic [3:0]     digits_q, digits_n, dig_inc;
	logic [31:0]    hex_q, hex_n, hex_acc;
	logic [esd_pkg::DIGIT_W-1:0] store_q [esd_pkg::STORE_DEPTH];
	logic           st_we;
	logic           is_hex;
	logic [3:0]     dval;

	// Hex digit decode: only 0-9, a-f and A-F count.
	always_comb begin
		is_hex = 1'b1;
		dval   = 4'd0;
		if (code_unit >= 16'h0030 && code_unit <= 16'h0039) begin
			dval = code_unit[3:0];
		end else if ((code_unit >= 16'h0061 && code_unit <= 16'h0066) ||
		             (code_unit >= 16'h0041 && code_unit <= 16'h0046)) begin
			dval = code_unit[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	assign dig_inc = digits_q + 4'd1;
	assign hex_acc = {hex_q[27:0], dval};

	always_comb begin
		mode_n        = mode_q;
		kind_n        = kind_q;
		digits_n      = digits_q;
		hex_n         = hex_q;
		st_we         = 1'b0;
		plan          = '0;
		plan.letter   = esd_pkg::kind_letter(kind_q);
		plan.text_end = stream_end;
		case (mode_q)
			esd_pkg::MODE_BACKSLASH: begin
				mode_n        = esd_pkg::MODE_IDLE;
				plan.main_cnt = 2'd1;
				case (code_unit)
					16'h0061: plan.base0 = 16'h0007;
					16'h0062: plan.base0 = 16'h0008;
					16'h0065: plan.base0 = esd_pkg::CH_ESC;
					16'h0066: plan.base0 = 16'h000C;
					16'h006E: plan.base0 = 16'h000A;
					16'h0072: plan.base0 = 16'h000D;
					16'h0074: plan.base0 = 16'h0009;
					16'h0076: plan.base0 = 16'h000B;
					16'h005C, 16'h003F, 16'h0027, 16'h0022: plan.base0 = code_unit;
					16'h0078, 16'h0075, 16'h0055: begin
						plan.main_cnt = 2'd0;
						mode_n        = esd_pkg::MODE_HEX;
						digits_n      = 4'd0;
						hex_n         = 32'd0;
						if (code_unit == 16'h0078) begin
							kind_n = esd_pkg::KIND_X;
						end else if (code_unit == 16'h0075) begin
							kind_n = esd_pkg::KIND_U4;
						end else begin
							kind_n = esd_pkg::KIND_U8;
						end
					end
					default: begin
						plan.main_cnt = 2'd2;
						plan.base0    = esd_pkg::CH_BSLASH;
						plan.base1    = code_unit;
					end
				endcase
			end
			esd_pkg::MODE_HEX: begin
				if (!is_hex) begin
					// Failed escape: replay what was taken, then treat the unit fresh.
					plan.rep_len = 4'd2 + digits_q;
					mode_n       = esd_pkg::MODE_IDLE;
					digits_n     = 4'd0;
					hex_n        = 32'd0;
					if (code_unit == esd_pkg::CH_BSLASH) begin
						mode_n = esd_pkg::MODE_BACKSLASH;
					end else begin
						plan.main_cnt = 2'd1;
						plan.base0    = code_unit;
					end
				end else begin
					st_we    = (digits_q < 4'd8);
					digits_n = dig_inc;
					hex_n    = hex_acc;
					if (dig_inc >= esd_pkg::kind_need(kind_q)) begin
						mode_n   = esd_pkg::MODE_IDLE;
						digits_n = 4'd0;
						hex_n    = 32'd0;
						if (kind_q != esd_pkg::KIND_X && kind_q != esd_pkg::KIND_U4 &&
						    (|hex_acc[31:16])) begin
							plan.main_cnt = 2'd2;
							plan.base0    = hex_acc[25:10];
							plan.add0     = esd_pkg::SURR_HI_OFS;
							plan.base1    = {6'd0, hex_acc[9:0]};
							plan.add1     = esd_pkg::SURR_LO_OFS;
						end else begin
							plan.main_cnt = 2'd1;
							plan.base0    = hex_acc[15:0];
						end
					end
				end
			end
			default: begin
				if (code_unit == esd_pkg::CH_BSLASH) begin
					mode_n = esd_pkg::MODE_BACKSLASH;
				end else begin
					plan.main_cnt = 2'd1;
					plan.base0    = code_unit;
				end
			end
		endcase

		// End of text flushes whatever escape is still pending.
		if (stream_end) begin
			if (mode_n == esd_pkg::MODE_BACKSLASH) begin
				plan.main_cnt = 2'd1;
				plan.base0    = esd_pkg::CH_BSLASH;
				plan.add0     = 16'd0;
			end else if (mode_n == esd_pkg::MODE_HEX) begin
				plan.rep_len = 4'd2 + digits_n;
				plan.letter  = esd_pkg::kind_letter(kind_n);
			end
			mode_n   = esd_pkg::MODE_IDLE;
			digits_n = 4'd0;
			hex_n    = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= esd_pkg::MODE_IDLE;
			kind_q   <= esd_pkg::KIND_X;
			digits_q <= 4'd0;
			hex_q    <= 32'd0;
		end else if (take) begin
			mode_q   <= mode_n;
			kind_q   <= kind_n;
			digits_q <= digits_n;
			hex_q    <= hex_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && st_we) begin
			store_q[digits_q[2:0]] <= code_unit[esd_pkg::DIGIT_W-1:0];
		end
	end

	assign rd_digit = store_q[rd_idx];

endmodule

// ----- rtl/esd_seq.sv -----
// Result sequencer: plays out one item's results through a shared adder into the output register.
module esd_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  esd_pkg::plan_t               plan,
	input  logic [esd_pkg::DIGIT_W-1:0]  rd_digit,
	output logic [2:0]                   rd_idx,
	output logic                         busy,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [15:0]                  out_unit,
	output logic                         run_last,
	output logic                         text_last
);

	esd_pkg::seq_state_t state_q, state_d;
	esd_pkg::plan_t      plan_q;
	logic [3:0]  pos_q, pos_d;
	logic [3:0]  total_q, total_new;
	logic [3:0]  rep_off, main_off;
	logic [15:0] op_a, op_b, sum;
	logic        load, last;
	logic        rv_q, run_last_q, text_last_q;
	logic [15:0] out_unit_q;

	assign total_new = plan.rep_len + {2'd0, plan.main_cnt};
	assign rep_off   = pos_q - 4'd2;
	assign main_off  = pos_q - plan_q.rep_len;
	assign rd_idx    = rep_off[2:0];
	assign load      = (state_q == esd_pkg::SQ_EMIT) && (!rv_q || result_ready);
	assign last      = (pos_q == total_q - 4'd1);
	assign busy      = (state_q != esd_pkg::SQ_IDLE);

	// Operand selection for the shared adder.
	always_comb begin
		op_a = 16'd0;
		op_b = 16'd0;
		if (pos_q < plan_q.rep_len) begin
			case (pos_q)
				4'd0:    op_a = esd_pkg::CH_BSLASH;
				4'd1:    op_a = {9'd0, plan_q.letter};
				default: op_a = {9'd0, rd_digit};
			endcase
		end else if (main_off == 4'd0) begin
			op_a = plan_q.base0;
			op_b = plan_q.add0;
		end else begin
			op_a = plan_q.base1;
			op_b = plan_q.add1;
		end
	end

	assign sum = op_a + op_b;

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		case (state_q)
			esd_pkg::SQ_IDLE: begin
				if (start && total_new != 4'd0) begin
					state_d = esd_pkg::SQ_EMIT;
					pos_d   = 4'd0;
				end
			end
			esd_pkg::SQ_EMIT: begin
				if (load) begin
					if (last) begin
						state_d = esd_pkg::SQ_IDLE;
					end else begin
						pos_d = pos_q + 4'd1;
					end
				end
			end
			default: state_d = esd_pkg::SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esd_pkg::SQ_IDLE;
			pos_q   <= 4'd0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			if (load) begin
				rv_q <= 1'b1;
			end else if (result_ready) begin
				rv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == esd_pkg::SQ_IDLE) begin
			plan_q  <= plan;
			total_q <= total_new;
		end
		if (load) begin
			out_unit_q  <= sum;
			run_last_q  <= last;
			text_last_q <= last && plan_q.text_end;
		end
	end

	assign result_valid = rv_q;
	assign out_unit     = out_unit_q;
	assign run_last     = run_last_q;
	assign text_last    = text_last_q;

`ifndef ASSERT_OFF
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == esd_pkg::SQ_EMIT) |-> (pos_q < total_q))
		else $error("result position ran past the item's result count");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == esd_pkg::SQ_EMIT) |-> (total_q <= 4'd10))
		else $error("more than ten results planned for one item");

	a_text_implies_run: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && text_last_q) |-> run_last_q)
		else $error("text end flagged on a result that does not close its item");

	a_empty_item: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == esd_pkg::SQ_IDLE && total_new == 4'd0) |=>
		(state_q == esd_pkg::SQ_IDLE))
		else $error("an item without results left the sequencer busy");
`endif

endmodule

// ----- rtl/escape_sequence_decoder_core.sv -----
// Top level of the streaming backslash escape decoder for UTF-16 text.
//
// The input channel (item_valid / item_ready) takes one UTF-16 code unit per item,
// with stream_end marking the final unit of a text. The output channel
// (result_valid / result_ready) delivers decoded units; run_last flags the last
// result caused by an input item and text_last the final result of the text.
// An input item causes zero to ten results: plain units and complete escapes give
// one or two, while a failed or cut-off numeric escape replays the backslash, the
// letter and the digits taken so far before the failing unit is handled afresh.
// Once an item is accepted, the block drops item_ready and plays its N results out
// one per cycle, while the receiver takes them, through a single shared 16-bit adder
// into the output register; item_ready rises again once the last one is loaded, and
// stays high for an item that causes no result. A new item is accepted while the
// last result still waits in the output register. When the receiver stalls, the
// sequencer holds its place and the output register keeps its result until it is
// taken. Reset returns the parser to idle with no escape pending and empties the
// output register.
module escape_sequence_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [15:0] code_unit,
	input  logic        stream_end,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] out_unit,
	output logic        run_last,
	output logic        text_last
);

	esd_pkg::plan_t plan;
	logic [2:0]     rd_idx;
	logic [esd_pkg::DIGIT_W-1:0] rd_digit;
	logic           busy;
	logic           take;

	// An item is taken only while the sequencer has nothing left to play out.
	assign item_ready = !busy;
	assign take       = item_valid && item_ready;

	// Parser: holds the escape state and the digit characters, and builds the plan.
	esd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.code_unit  (code_unit),
		.stream_end (stream_end),
		.rd_idx     (rd_idx),
		.rd_digit   (rd_digit),
		.plan       (plan)
	);

	// Sequencer: steps through the plan, one result per cycle while the receiver keeps up.
	esd_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (take),
		.plan         (plan),
		.rd_digit     (rd_digit),
		.rd_idx       (rd_idx),
		.busy         (busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_unit     (out_unit),
		.run_last     (run_last),
		.text_last    (text_last)
	);

endmodule

// ----- tb/sv/escape_sequence_decoder_core_tb.sv -----
// Self-checking testbench of the escape sequence decoder core with its own decoding predictor.
`timescale 1ns / 100ps

module escape_sequence_decoder_core_tb;

	// Character codes used by the escapes and by the stimulus.
	localparam logic [15:0] CH_LOWER_X = 16'h0078;
	localparam logic [15:0] CH_LOWER_U = 16'h0075;
	localparam logic [15:0] CH_UPPER_U = 16'h0055;
	localparam logic [15:0] CH_ZERO    = 16'h0030;

	// Least number of input items in the whole run.
	localparam int unsigned TEXT_UNITS = 370;
	// Items at the end of the run during which neither side idles.
	localparam int unsigned QUIET_TAIL = 60;
	// Length of the one long receiver hold-off and the item count that starts it.
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned HOLD_AFTER  = 150;
	// The slowest correct run goes without a handshake on one side or the other for
	// little more than the long hold-off, as sender gaps and receiver stalls are drawn
	// short. The limit takes that several times over.
	localparam int unsigned STUCK_LIMIT = 1000;
	// Cycles left after the last expected result, so that a stray result can still show.
	localparam int unsigned DRAIN_CYCLES = 32;

	typedef struct {
		logic [15:0] unit;
		logic        fin;
	} text_unit_t;

	typedef struct {
		logic [15:0] unit;
		logic        run_end;
		logic        text_end;
	} decoded_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [15:0] code_unit;
	logic        stream_end;
	logic        result_valid;
	logic        result_ready;
	logic [15:0] out_unit;
	logic        run_last;
	logic        text_last;

	escape_sequence_decoder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.code_unit    (code_unit),
		.stream_end   (stream_end),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_unit     (out_unit),
		.run_last     (run_last),
		.text_last    (text_last)
	);

	// Items still to be offered, and decoded units still to come out.
	text_unit_t  send_queue[$];
	decoded_t    expected_units[$];

	// Predictor state: the parser as the decoder should hold it.
	esd_pkg::mode_t dec_mode;
	esd_pkg::kind_t dec_kind;
	logic [3:0]  dec_count;
	logic [31:0] dec_value;
	logic [6:0]  digit_log [8];
	logic [15:0] emit_buf[$];

	int unsigned total_units;
	int unsigned units_taken;
	int unsigned errors;
	logic        unit_fire;
	logic        quiet;

	// The last part of the run goes without any idling on either side.
	assign quiet = (units_taken + QUIET_TAIL >= total_units);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Weight of a hex digit, or -1 when the unit is not one of 0-9, a-f, A-F.
	function automatic int hex_weight(input logic [15:0] u);
		if (u >= 16'h0030 && u <= 16'h0039)
			return int'(u - 16'h0030);
		if (u >= 16'h0061 && u <= 16'h0066)
			return int'(u - 16'h0061) + 10;
		if (u >= 16'h0041 && u <= 16'h0046)
			return int'(u - 16'h0041) + 10;
		return -1;
	endfunction

	task automatic emit_unit(input logic [15:0] u);
		emit_buf.push_back(u);
	endtask

	// A failed or cut-off numeric escape comes out literally: the backslash, its
	// letter and the digits it had taken.
	task automatic replay_escape();
		emit_unit(esd_pkg::CH_BSLASH);
		case (dec_kind)
			esd_pkg::KIND_X:  emit_unit(CH_LOWER_X);
			esd_pkg::KIND_U4: emit_unit(CH_LOWER_U);
			default:          emit_unit(CH_UPPER_U);
		endcase
		for (int i = 0; i < 8 && i < int'(dec_count); i++)
			emit_unit({9'd0, digit_log[i]});
		dec_mode  = esd_pkg::MODE_IDLE;
		dec_count = '0;
		dec_value = '0;
	endtask

	// A unit seen with no escape pending either opens one or passes through.
	task automatic start_fresh(input logic [15:0] u);
		if (u == esd_pkg::CH_BSLASH)
			dec_mode = esd_pkg::MODE_BACKSLASH;
		else
			emit_unit(u);
	endtask

	// Decodes one accepted item and queues the units that it must cause.
	task automatic decode_unit(input logic [15:0] cu, input logic fin);
		int       d;
		decoded_t exp_unit;
		emit_buf.delete();
		case (dec_mode)
			esd_pkg::MODE_BACKSLASH: begin
				dec_mode = esd_pkg::MODE_IDLE;
				case (cu)
					16'h0061: emit_unit(16'h0007);        // \a bell
					16'h0062: emit_unit(16'h0008);        // \b backspace
					16'h0065: emit_unit(esd_pkg::CH_ESC); // \e escape
					16'h0066: emit_unit(16'h000C);        // \f form feed
					16'h006E: emit_unit(16'h000A);        // \n line feed
					16'h0072: emit_unit(16'h000D);        // \r carriage return
					16'h0074: emit_unit(16'h0009);        // \t tab
					16'h0076: emit_unit(16'h000B);        // \v vertical tab
					esd_pkg::CH_BSLASH, 16'h003F, 16'h0027, 16'h0022: emit_unit(cu);
					CH_LOWER_X, CH_LOWER_U, CH_UPPER_U: begin
						dec_kind  = (cu == CH_LOWER_X) ? esd_pkg::KIND_X :
						            (cu == CH_LOWER_U) ? esd_pkg::KIND_U4 : esd_pkg::KIND_U8;
						dec_mode  = esd_pkg::MODE_HEX;
						dec_count = '0;
						dec_value = '0;
					end
					default: begin
						emit_unit(esd_pkg::CH_BSLASH);
						emit_unit(cu);
					end
				endcase
			end
			esd_pkg::MODE_HEX: begin
				d = hex_weight(cu);
				if (d < 0) begin
					replay_escape();
					start_fresh(cu);
				end else begin
					if (dec_count < 4'd8)
						digit_log[dec_count[2:0]] = cu[6:0];
					dec_count = dec_count + 4'd1;
					dec_value = {dec_value[27:0], 4'(d)};
					if ((dec_kind == esd_pkg::KIND_X && dec_count >= 4'd2) ||
					    (dec_kind == esd_pkg::KIND_U4 && dec_count >= 4'd4) ||
					    dec_count >= 4'd8) begin
						// Large \U values leave as a surrogate pair, each half cut to 16 bits.
						if (dec_kind != esd_pkg::KIND_X && dec_kind != esd_pkg::KIND_U4 &&
						    dec_value > 32'h0000_FFFF) begin
							emit_unit(dec_value[25:10] + esd_pkg::SURR_HI_OFS);
							emit_unit({6'd0, dec_value[9:0]} + esd_pkg::SURR_LO_OFS);
						end else begin
							emit_unit(dec_value[15:0]);
						end
						dec_mode  = esd_pkg::MODE_IDLE;
						dec_count = '0;
						dec_value = '0;
					end
				end
			end
			default: start_fresh(cu);
		endcase

		// The end of the text flushes whatever escape is still open.
		if (fin) begin
			if (dec_mode == esd_pkg::MODE_BACKSLASH)
				emit_unit(esd_pkg::CH_BSLASH);
			else if (dec_mode == esd_pkg::MODE_HEX)
				replay_escape();
			dec_mode  = esd_pkg::MODE_IDLE;
			dec_count = '0;
			dec_value = '0;
		end

		foreach (emit_buf[i]) begin
			exp_unit.unit     = emit_buf[i];
			exp_unit.run_end  = (i == emit_buf.size() - 1);
			exp_unit.text_end = exp_unit.run_end && fin;
			expected_units.push_back(exp_unit);
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic queue_unit(input logic [15:0] u, input logic fin);
		text_unit_t t;
		t.unit = u;
		t.fin  = fin;
		send_queue.push_back(t);
	endtask

	function automatic logic [15:0] simple_letter(input int unsigned idx);
		case (idx)
			0:       return 16'h0061;  // a
			1:       return 16'h0062;  // b
			2:       return 16'h0065;  // e
			3:       return 16'h0066;  // f
			4:       return 16'h006E;  // n
			5:       return 16'h0072;  // r
			6:       return 16'h0074;  // t
			7:       return 16'h0076;  // v
			8:       return esd_pkg::CH_BSLASH;
			9:       return 16'h003F;  // question mark
			10:      return 16'h0027;  // single quote
			default: return 16'h0022;  // double quote
		endcase
	endfunction

	// A random hex digit character, letters in either case.
	function automatic logic [15:0] rand_hex_char();
		int unsigned v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return CH_ZERO + 16'(v);
		if (v < 16)
			return 16'h0061 + 16'(v - 10);
		return 16'h0041 + 16'(v - 16);
	endfunction

	// A unit that breaks a numeric escape: a new backslash, a character just
	// outside the hex ranges, or any other non-hex unit.
	function automatic logic [15:0] rand_non_hex();
		logic [15:0] u;
		case ($urandom_range(0, 8))
			0, 1: return esd_pkg::CH_BSLASH;
			2:    return 16'h002F;  // just below 0
			3:    return 16'h003A;  // just above 9
			4:    return 16'h0040;  // just below A
			5:    return 16'h0047;  // just above F
			6:    return 16'h0060;  // just below a
			7:    return 16'h0067;  // just above f
			default: begin
				do
					u = 16'($urandom);
				while (hex_weight(u) >= 0);
				return u;
			end
		endcase
	endfunction

	// Appends one random stretch of text. Much of it is well-formed escapes with
	// random content, the rest plain units, unknown and broken escapes.
	task automatic add_text_chunk();
		int unsigned pick;
		int unsigned sel;
		int unsigned need;
		int unsigned cut;
		logic        zero_lead;
		logic [15:0] letter;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			queue_unit(16'($urandom), 1'b0);
		end else if (pick < 50) begin
			queue_unit(esd_pkg::CH_BSLASH, 1'b0);
			queue_unit(simple_letter($urandom_range(0, 11)), 1'b0);
		end else if (pick < 85) begin
			sel    = $urandom_range(0, 2);
			letter = (sel == 0) ? CH_LOWER_X : (sel == 1) ? CH_LOWER_U : CH_UPPER_U;
			need   = (sel == 0) ? 2 : (sel == 1) ? 4 : 8;
			queue_unit(esd_pkg::CH_BSLASH, 1'b0);
			queue_unit(letter, 1'b0);
			if (pick < 72) begin
				// Leading zeros keep some \U values inside the basic plane.
				zero_lead = ($urandom_range(0, 2) == 0);
				for (int i = 0; i < int'(need); i++)
					queue_unit((sel == 2 && i < 4 && zero_lead) ? CH_ZERO : rand_hex_char(),
						1'b0);
			end else begin
				cut = $urandom_range(0, need - 1);
				for (int i = 0; i < int'(cut); i++)
					queue_unit(rand_hex_char(), 1'b0);
				if ($urandom_range(0, 1) == 0)
					queue_unit(rand_non_hex(), 1'b0);
				else
					send_queue[send_queue.size() - 1].fin = 1'b1;
			end
		end else if (pick < 95) begin
			queue_unit(esd_pkg::CH_BSLASH, 1'b0);
			queue_unit(16'($urandom), 1'b0);
		end else begin
			queue_unit(esd_pkg::CH_BSLASH, 1'b1);
		end
		if ($urandom_range(0, 11) == 0)
			send_queue[send_queue.size() - 1].fin = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sender: offers items at the falling edge, in random bursts of idling.
	// ------------------------------------------------------------------
	int unsigned send_gap;
	int unsigned send_rate;
	int unsigned send_cycles;

	always @(negedge clk) begin
		text_unit_t head;
		logic       next_valid;
		next_valid = item_valid;
		if (item_valid && unit_fire)
			next_valid = 1'b0;
		if (arst_n) begin
			// The idling rate changes now and then; a rate of zero leaves stretches
			// with no gaps at all.
			if (send_cycles % 64 == 0)
				send_rate = $urandom_range(0, 4);
			send_cycles++;
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (send_queue.size() != 0) begin
					if (!quiet && $urandom_range(0, 15) < send_rate) begin
						send_gap = $urandom_range(1, 8) - 1;
					end else begin
						head = send_queue.pop_front();
						next_valid = 1'b1;
						code_unit  <= head.unit;
						stream_end <= head.fin;
					end
				end
			end
		end
		item_valid <= next_valid;
	end

	// ------------------------------------------------------------------
	// Receiver: drives result_ready at the falling edge. Once in the run it holds
	// off for a long stretch so that the decoder fills up and stalls its input.
	// ------------------------------------------------------------------
	int unsigned stall_left;
	int unsigned hold_left;
	int unsigned recv_rate;
	int unsigned recv_cycles;
	logic        hold_done;

	always @(negedge clk) begin
		logic ready_next;
		ready_next = 1'b0;
		if (arst_n) begin
			if (recv_cycles % 64 == 0)
				recv_rate = $urandom_range(0, 4);
			recv_cycles++;
			if (!hold_done && units_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0)
				hold_left--;
			else if (stall_left != 0)
				stall_left--;
			else if (!quiet && $urandom_range(0, 15) < recv_rate)
				stall_left = $urandom_range(1, 8) - 1;
			else
				ready_next = 1'b1;
		end
		result_ready <= ready_next;
	end

	// ------------------------------------------------------------------
	// Monitor: at the rising edge, checks each result against the oldest expected
	// unit, then predicts the results of an item accepted at the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		decoded_t want;
		unit_fire <= item_valid && item_ready;
		if (result_valid && result_ready) begin
			if (expected_units.size() == 0) begin
				$error("unexpected result: out_unit %h run_last %b text_last %b",
					out_unit, run_last, text_last);
				errors++;
			end else begin
				want = expected_units.pop_front();
				if (out_unit !== want.unit) begin
					$error("out_unit: expected %h, actual %h", want.unit, out_unit);
					errors++;
				end
				if (run_last !== want.run_end) begin
					$error("run_last: expected %b, actual %b", want.run_end, run_last);
					errors++;
				end
				if (text_last !== want.text_end) begin
					$error("text_last: expected %b, actual %b", want.text_end, text_last);
					errors++;
				end
			end
		end
		if (item_valid && item_ready) begin
			decode_unit(code_unit, stream_end);
			units_taken <= units_taken + 1;
		end
	end

	// Watchdog: a run in which no item moves on either side for too long is hung.
	int unsigned stuck_cycles;

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stuck_cycles = 0;
		else if (arst_n)
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		code_unit    = '0;
		stream_end   = 1'b0;
		result_ready = 1'b0;
		unit_fire    = 1'b0;
		units_taken  = 0;
		errors       = 0;
		send_gap     = 0;
		send_rate    = 0;
		send_cycles  = 0;
		stall_left   = 0;
		hold_left    = 0;
		recv_rate    = 0;
		recv_cycles  = 0;
		hold_done    = 1'b0;
		stuck_cycles = 0;
		dec_mode     = esd_pkg::MODE_IDLE;
		dec_kind     = esd_pkg::KIND_X;
		dec_count    = '0;
		dec_value    = '0;
		foreach (digit_log[i])
			digit_log[i] = '0;

		// Directed text: extreme units, a simple escape, an unknown escape, a hex
		// escape broken by a non-digit, one broken by a new backslash, an escape cut
		// off by the end of the text, and a lone backslash at the end of a text.
		queue_unit(16'h0000, 1'b0);
		queue_unit(16'hFFFF, 1'b0);
		queue_unit(esd_pkg::CH_BSLASH, 1'b0);
		queue_unit(16'h0065, 1'b0);      // e
		queue_unit(esd_pkg::CH_BSLASH, 1'b0);
		queue_unit(16'h0071, 1'b0);      // q, no such escape
		queue_unit(esd_pkg::CH_BSLASH, 1'b0);
		queue_unit(CH_LOWER_X, 1'b0);
		queue_unit(16'h0041, 1'b0);      // A
		queue_unit(16'h0047, 1'b0);      // G ends the escape
		queue_unit(esd_pkg::CH_BSLASH, 1'b0);
		queue_unit(CH_LOWER_X, 1'b0);
		queue_unit(esd_pkg::CH_BSLASH, 1'b0);     // breaks \x and opens a new escape
		queue_unit(16'h006E, 1'b0);      // n
		queue_unit(esd_pkg::CH_BSLASH, 1'b0);
		queue_unit(CH_LOWER_U, 1'b0);
		queue_unit(16'h0066, 1'b0);      // f
		queue_unit(16'h0039, 1'b1);      // 9, end of text cuts the escape off
		queue_unit(16'h005A, 1'b0);      // Z
		queue_unit(esd_pkg::CH_BSLASH, 1'b1);     // lone backslash closes the text

		while (send_queue.size() < TEXT_UNITS)
			add_text_chunk();
		send_queue[send_queue.size() - 1].fin = 1'b1;
		total_units = send_queue.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every item to be taken and every expected unit to arrive, then
		// give the decoder time to show any result that should not be there.
		while (units_taken != total_units || expected_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
